// File: rtl/wqr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the web-safe quantizer
// with run-length output. No dependencies; every other file imports this.
package wqr_pkg;

  // Column counter width and the fixed field widths
  localparam int COLUMN_BITS = 16;
  localparam int CH_W        = 8;
  localparam int CODE_W      = 12;
  localparam int LEN_W       = 16;
  localparam int WIDTH_W     = 16;
  localparam int CMP_W       = (COLUMN_BITS > WIDTH_W) ? COLUMN_BITS : WIDTH_W;

  // Palette constants
  localparam int LEVEL_DIV  = 43;
  localparam int LEVELS     = 6;
  localparam int LEVEL_MAX  = 5;
  localparam logic [CODE_W-1:0] TRANSPARENT_CODE = 12'hFFF;
  localparam logic [LEN_W-1:0]  LEN_MAX          = '1;

  // Configuration port
  localparam int APB_DW = 32;
  localparam int APB_AW = 2;
  localparam logic [APB_AW-1:0] ADDR_ROW_WIDTH = 2'd0;

  // Result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef logic [2:0] level_t;

  typedef struct packed {
    logic [CH_W-1:0] fg_red;
    logic [CH_W-1:0] fg_green;
    logic [CH_W-1:0] fg_blue;
    logic [CH_W-1:0] bg_red;
    logic [CH_W-1:0] bg_green;
    logic [CH_W-1:0] bg_blue;
    logic            image_start;
  } pix_t;

  typedef struct packed {
    logic [CODE_W-1:0] run_code;
    logic [LEN_W-1:0]  run_length;
    logic              row_end;
    logic              fg_present;
    logic              bg_changed;
    logic [CH_W-1:0]   background_red;
    logic [CH_W-1:0]   background_green;
    logic [CH_W-1:0]   background_blue;
  } run_t;

  // (c+1)/43 as a chain of threshold compares: level k starts at 43*k-1
  function automatic level_t level_of(input logic [CH_W-1:0] c);
    level_t lv;
    lv = '0;
    for (int k = 1; k <= LEVEL_MAX; k++) begin
      if ({1'b0, c} >= (CH_W + 1)'(LEVEL_DIV * k - 1)) begin
        lv = level_t'(k);
      end
    end
    return lv;
  endfunction

  // Web-safe index: b + 6*(g + 6*r)
  function automatic logic [CODE_W-1:0] code_of(input logic [CH_W-1:0] r,
                                                input logic [CH_W-1:0] g,
                                                input logic [CH_W-1:0] b);
    logic [CODE_W-1:0] rg;
    rg = CODE_W'(level_of(g)) + CODE_W'(LEVELS) * CODE_W'(level_of(r));
    return CODE_W'(level_of(b)) + CODE_W'(LEVELS) * rg;
  endfunction

endpackage

// File: rtl/wqr_pix_if.sv
`timescale 1ns / 1ps
// Pixel channel: valid/ready handshake with one foreground/background pair.
// Depends on wqr_pkg for the payload type.
interface wqr_pix_if;
  import wqr_pkg::*;

  logic valid;
  logic ready;
  pix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/wqr_run_if.sv
`timescale 1ns / 1ps
// Run channel: valid/ready handshake carrying one run word per beat.
// Depends on wqr_pkg for the payload type.
interface wqr_run_if;
  import wqr_pkg::*;

  logic valid;
  logic ready;
  run_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/websafe_quantize_rle.sv
`timescale 1ns / 1ps
// Web-safe quantizer with run-length output; uses wqr_pkg, wqr_pix_if, wqr_run_if.
// Each pixel is coded from the input register and its run beats go through the
//   result queue. Throughput: one pixel per cycle while the queue has room for
//   two runs; the run port moves one beat per cycle while ready is high, so a
//   pixel that closes a run and a row puts two beats on the run port.
// Reset: row_width returns to 1, run state, flags and background reference clear.
module websafe_quantize_rle (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wqr_pkg::APB_AW-1:0]  paddr,
  input  logic [wqr_pkg::APB_DW-1:0]  pwdata,
  output logic [wqr_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  wqr_pix_if.sink                     pix_i,
  wqr_run_if.source                   run_o
);
  import wqr_pkg::*;

  localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

  // Configuration
  logic [WIDTH_W-1:0] row_width_q;
  logic               cfg_wr;

  // Input register
  logic s1_valid_q;
  pix_t s1_q;
  logic fire;

  // Run state
  logic [COLUMN_BITS-1:0]   col_q;
  logic [CODE_W-1:0]        cur_code_q;
  logic [LEN_W-1:0]         cur_len_q;
  logic [3*CH_W-1:0]        bg_ref_q;
  logic                     fg_seen_q;
  logic                     bg_var_q;

  // Coding logic
  logic                     start;
  logic [CODE_W-1:0]        base_code;
  logic [LEN_W-1:0]         base_len;
  logic [COLUMN_BITS-1:0]   base_col;
  logic [3*CH_W-1:0]        ref_c;
  logic [3*CH_W-1:0]        bg_pack;
  logic [3*CH_W-1:0]        fg_pack;
  logic                     differ;
  logic                     fg_n;
  logic                     bgvar_n;
  logic [CODE_W-1:0]        code_c;
  logic                     extend;
  logic                     emit_a;
  logic [LEN_W-1:0]         len_n;
  logic [COLUMN_BITS-1:0]   col_inc;
  logic [CMP_W-1:0]         width_ext;
  logic [CMP_W-1:0]         width_lim;
  logic                     row_end_c;
  run_t                     res_a;
  run_t                     res_b;
  run_t                     first_res;
  logic [1:0]               push_cnt;

  // Result queue
  run_t                     oq_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]      wr_ptr_q;
  logic [OQ_PTR_W-1:0]      rd_ptr_q;
  logic [OQ_CNT_W-1:0]      cnt_q;
  logic                     pop;

  // Configuration port: single register, no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_ROW_WIDTH);
  assign prdata = (paddr == ADDR_ROW_WIDTH) ? APB_DW'(row_width_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= WIDTH_W'(1);
    end else if (cfg_wr) begin
      row_width_q <= pwdata[WIDTH_W-1:0];
    end
  end

  // Advance the input register when the queue has room for two runs
  assign fire        = s1_valid_q && (cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign pix_i.ready = !s1_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix_i.ready) begin
      s1_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_i.ready && pix_i.valid) begin
      s1_q <= pix_i.data;
    end
  end

  // Image start clears the run state and reloads the background reference
  assign start     = s1_q.image_start;
  assign bg_pack   = {s1_q.bg_red, s1_q.bg_green, s1_q.bg_blue};
  assign fg_pack   = {s1_q.fg_red, s1_q.fg_green, s1_q.fg_blue};
  assign base_code = start ? TRANSPARENT_CODE : cur_code_q;
  assign base_len  = start ? '0 : cur_len_q;
  assign base_col  = start ? '0 : col_q;
  assign ref_c     = start ? bg_pack : bg_ref_q;

  // Flags and pixel code
  assign differ  = (fg_pack != bg_pack);
  assign bgvar_n = (!start && bg_var_q) || (bg_pack != ref_c);
  assign fg_n    = (!start && fg_seen_q) || (differ && (fg_pack != '0));
  assign code_c  = differ ? code_of(s1_q.fg_red, s1_q.fg_green, s1_q.fg_blue)
                          : TRANSPARENT_CODE;

  // Extend the open run or close it; length saturates
  assign extend = (base_len != '0) && (code_c == base_code);
  assign emit_a = (base_len != '0) && !extend;
  assign len_n  = !extend ? LEN_W'(1)
                : (base_len == LEN_MAX) ? base_len : base_len + LEN_W'(1);

  // Row end: zero width acts as one, width clamps to the counter range
  assign col_inc   = base_col + COLUMN_BITS'(1);
  assign width_ext = (row_width_q == '0) ? CMP_W'(1) : CMP_W'(row_width_q);
  assign width_lim = (width_ext > CMP_W'(COL_MAX)) ? CMP_W'(COL_MAX) : width_ext;
  assign row_end_c = (col_inc == '0) || (CMP_W'(col_inc) >= width_lim);

  // Assemble the two possible run beats
  always_comb begin
    res_a.run_code         = base_code;
    res_a.run_length       = base_len;
    res_a.row_end          = 1'b0;
    res_a.fg_present       = fg_n;
    res_a.bg_changed       = bgvar_n;
    res_a.background_red   = ref_c[3*CH_W-1:2*CH_W];
    res_a.background_green = ref_c[2*CH_W-1:CH_W];
    res_a.background_blue  = ref_c[CH_W-1:0];
    res_b                  = res_a;
    res_b.run_code         = code_c;
    res_b.run_length       = len_n;
    res_b.row_end          = 1'b1;
  end

  assign first_res = emit_a ? res_a : res_b;
  assign push_cnt  = fire ? (2'(emit_a) + 2'(row_end_c)) : 2'd0;

  // Update run state on each coded pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      cur_code_q <= TRANSPARENT_CODE;
      cur_len_q  <= '0;
      bg_ref_q   <= '0;
      fg_seen_q  <= 1'b0;
      bg_var_q   <= 1'b0;
    end else if (fire) begin
      col_q      <= row_end_c ? '0 : col_inc;
      cur_code_q <= row_end_c ? TRANSPARENT_CODE : code_c;
      cur_len_q  <= row_end_c ? '0 : len_n;
      bg_ref_q   <= ref_c;
      fg_seen_q  <= fg_n;
      bg_var_q   <= bgvar_n;
    end
  end

  // Result queue: up to two writes, one read per cycle
  assign pop         = run_o.valid && run_o.ready;
  assign run_o.valid = (cnt_q != '0);
  assign run_o.data  = oq_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_cnt != 2'd0) begin
      oq_q[wr_ptr_q] <= first_res;
    end
    if (push_cnt == 2'd2) begin
      oq_q[wr_ptr_q + OQ_PTR_W'(1)] <= res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(push_cnt);
      rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(pop);
      cnt_q    <= cnt_q + OQ_CNT_W'(push_cnt) - OQ_CNT_W'(pop);
    end
  end

  // Checks
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue overflow");

  a_row_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && row_end_c) |=> (col_q == '0) && (cur_len_q == '0))
    else $error("row end did not clear run state");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_o.valid |-> (run_o.data.run_length != '0))
    else $error("empty run offered");

  a_open_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_len_q == '0) |-> (cur_code_q == TRANSPARENT_CODE))
    else $error("closed run holds a palette code");

endmodule
